// ===== src/htmlesc_pkg.sv =====
// Shared types, constants and entity tables for the HTML escaper.
package htmlesc_pkg;

  localparam int TAB_STOP    = 4;
  localparam int MAX_RESULTS = 6;
  localparam int COL_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TOT_W       = $clog2(TAB_STOP + 1) + 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_NBSP  = 16'h00A0;
  localparam logic [15:0] CH_LT    = 16'h003C;
  localparam logic [15:0] CH_GT    = 16'h003E;
  localparam logic [15:0] CH_QUOT  = 16'h0022;
  localparam logic [15:0] CH_APOS  = 16'h0027;
  localparam logic [15:0] CH_AMP   = 16'h0026;

  localparam logic [47:0] STR_BR   = "<br>  ";
  localparam logic [47:0] STR_LT   = "&lt;  ";
  localparam logic [47:0] STR_GT   = "&gt;  ";
  localparam logic [47:0] STR_QUOT = "&quot;";
  localparam logic [47:0] STR_APOS = "&apos;";
  localparam logic [47:0] STR_AMP  = "&amp; ";

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_BR,
    KIND_TAB,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_APOS,
    KIND_AMP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [15:0]       ch;
    logic [CNT_W-1:0]  count;
  } token_t;

  function automatic logic is_white(input logic [15:0] c);
    is_white = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
               c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
               c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
               c == 16'h3000;
  endfunction

  function automatic logic [CNT_W-1:0] run_len(input token_t t);
    unique case (t.kind)
      KIND_PASS: run_len = CNT_W'(1);
      KIND_BR:   run_len = CNT_W'(4);
      KIND_TAB:  run_len = t.count;
      KIND_LT:   run_len = CNT_W'(4);
      KIND_GT:   run_len = CNT_W'(4);
      KIND_QUOT: run_len = CNT_W'(6);
      KIND_APOS: run_len = CNT_W'(6);
      KIND_AMP:  run_len = CNT_W'(5);
      default:   run_len = CNT_W'(1);
    endcase
  endfunction

  function automatic logic [15:0] str_char(input logic [47:0] s, input logic [2:0] idx);
    str_char = {8'h00, s[47 - 8 * idx -: 8]};
  endfunction

  function automatic logic [15:0] run_char(input token_t t, input logic [2:0] idx);
    unique case (t.kind)
      KIND_PASS: run_char = t.ch;
      KIND_BR:   run_char = str_char(STR_BR, idx);
      KIND_TAB:  run_char = CH_NBSP;
      KIND_LT:   run_char = str_char(STR_LT, idx);
      KIND_GT:   run_char = str_char(STR_GT, idx);
      KIND_QUOT: run_char = str_char(STR_QUOT, idx);
      KIND_APOS: run_char = str_char(STR_APOS, idx);
      KIND_AMP:  run_char = str_char(STR_AMP, idx);
      default:   run_char = t.ch;
    endcase
  endfunction

endpackage

// ===== src/htmlesc_front.sv =====
// Front end: classifies each input beat, tracks column and space state, emits a token.
module htmlesc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           character,
  input  logic                  start_of_text,
  input  logic                  full,
  output logic                  push,
  output htmlesc_pkg::token_t   token
);

  logic [htmlesc_pkg::COL_W-1:0] column_mod;
  logic [htmlesc_pkg::COL_W-1:0] column_mod_next;
  logic                          previous_was_space;
  logic [htmlesc_pkg::COL_W-1:0] col;
  logic                          prev;
  logic [htmlesc_pkg::TOT_W-1:0] total;

  assign in_stall = full;
  assign push     = in_valid && !full;
  assign col      = start_of_text ? '0 : column_mod;
  assign prev     = start_of_text ? 1'b0 : previous_was_space;

  always_comb begin
    if (col == '0) begin
      total = htmlesc_pkg::TOT_W'(1);
    end else begin
      total = htmlesc_pkg::TOT_W'(htmlesc_pkg::TAB_STOP) - htmlesc_pkg::TOT_W'(col) +
              htmlesc_pkg::TOT_W'(1);
    end
  end

  always_comb begin
    token.ch    = character;
    token.count = htmlesc_pkg::CNT_W'(1);
    priority if (character == htmlesc_pkg::CH_LF) begin
      token.kind = htmlesc_pkg::KIND_BR;
    end else if (character == htmlesc_pkg::CH_TAB) begin
      token.kind = htmlesc_pkg::KIND_TAB;
      if (total > htmlesc_pkg::TOT_W'(htmlesc_pkg::MAX_RESULTS)) begin
        token.count = htmlesc_pkg::CNT_W'(htmlesc_pkg::MAX_RESULTS);
      end else begin
        token.count = total[htmlesc_pkg::CNT_W-1:0];
      end
    end else if (htmlesc_pkg::is_white(character)) begin
      token.kind = htmlesc_pkg::KIND_PASS;
      token.ch   = prev ? htmlesc_pkg::CH_NBSP : htmlesc_pkg::CH_SPACE;
    end else if (character == htmlesc_pkg::CH_LT) begin
      token.kind = htmlesc_pkg::KIND_LT;
    end else if (character == htmlesc_pkg::CH_GT) begin
      token.kind = htmlesc_pkg::KIND_GT;
    end else if (character == htmlesc_pkg::CH_QUOT) begin
      token.kind = htmlesc_pkg::KIND_QUOT;
    end else if (character == htmlesc_pkg::CH_APOS) begin
      token.kind = htmlesc_pkg::KIND_APOS;
    end else if (character == htmlesc_pkg::CH_AMP) begin
      token.kind = htmlesc_pkg::KIND_AMP;
    end else begin
      token.kind = htmlesc_pkg::KIND_PASS;
    end
  end

  always_comb begin
    if (character == htmlesc_pkg::CH_LF || character == htmlesc_pkg::CH_TAB ||
        col == htmlesc_pkg::COL_W'(htmlesc_pkg::TAB_STOP - 1)) begin
      column_mod_next = (htmlesc_pkg::TAB_STOP > 1) ? htmlesc_pkg::COL_W'(1) : '0;
      if (!(character == htmlesc_pkg::CH_LF || character == htmlesc_pkg::CH_TAB)) begin
        column_mod_next = '0;
      end
    end else begin
      column_mod_next = col + htmlesc_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_mod         <= '0;
      previous_was_space <= 1'b0;
    end else if (push) begin
      column_mod         <= column_mod_next;
      previous_was_space <= (character == htmlesc_pkg::CH_SPACE);
    end
  end

endmodule

// ===== src/htmlesc_fifo.sv =====
// Token queue between the front and back ends.
module htmlesc_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  htmlesc_pkg::token_t  wr_token,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output htmlesc_pkg::token_t  rd_token
);

  htmlesc_pkg::token_t           entries [htmlesc_pkg::FIFO_DEPTH];
  logic [htmlesc_pkg::PTR_W-1:0] wr_ptr;
  logic [htmlesc_pkg::PTR_W-1:0] rd_ptr;
  logic [htmlesc_pkg::PTR_W:0]   fill;

  assign full      = (fill == (htmlesc_pkg::PTR_W + 1)'(htmlesc_pkg::FIFO_DEPTH));
  assign not_empty = (fill != '0);
  assign rd_token  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + htmlesc_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + htmlesc_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (htmlesc_pkg::PTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (htmlesc_pkg::PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== src/htmlesc_back.sv =====
// Back end: expands each token into its run of output beats through an output register.
module htmlesc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 not_empty,
  input  htmlesc_pkg::token_t  token,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_character,
  output logic                 last_of_run
);

  logic [2:0]                    idx;
  logic [htmlesc_pkg::CNT_W-1:0] len;
  logic                          load;
  logic                          last;

  assign len  = htmlesc_pkg::run_len(token);
  assign last = (htmlesc_pkg::CNT_W'(idx) + htmlesc_pkg::CNT_W'(1) >= len);
  assign load = not_empty && (!out_valid || !out_stall);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_character <= htmlesc_pkg::run_char(token, idx);
      last_of_run   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

// ===== src/text_to_html_escaper_core.sv =====
// Top level of the HTML escaper: front end, token queue and back end.
// An accepted input beat is written into the token queue as a token; the back end then loads
// the first output beat of that token into its output register.
// Throughput: one input beat per cycle into a four-entry token queue while it is not full;
// one output beat per cycle while out_stall is low, each item giving a run of 1 to 6 beats.
// Reset: synchronous; clears column, previous-space mark, queue and output valid.
module text_to_html_escaper_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] character,
  input  logic        start_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_character,
  output logic        last_of_run
);

  logic                full;
  logic                push;
  logic                pop;
  logic                not_empty;
  htmlesc_pkg::token_t wr_token;
  htmlesc_pkg::token_t rd_token;

  htmlesc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .character     (character),
    .start_of_text (start_of_text),
    .full          (full),
    .push          (push),
    .token         (wr_token)
  );

  htmlesc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_token  (wr_token),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_token  (rd_token)
  );

  htmlesc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (not_empty),
    .token         (rd_token),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .last_of_run   (last_of_run)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for text_to_html_escaper_core with random flow control.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 320;

  typedef struct {
    logic [15:0] ch;
    logic        sot;
  } text_item_t;

  typedef struct {
    logic [15:0] ch;
    logic        last;
  } html_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] character = '0;
  logic        start_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_character;
  logic        last_of_run;

  text_item_t  char_queue[$];
  html_beat_t  expected_beats[$];

  logic [htmlesc_pkg::COL_W-1:0] col_mod = '0;
  logic                          prev_space = 1'b0;

  int errors = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int texts_made = 0;
  int cycles = 0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold1_done = 0;
  bit hold2_done = 0;
  logic stall_next;
  text_item_t  next_item;
  html_beat_t  got_exp;

  text_to_html_escaper_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .start_of_text(start_of_text),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .last_of_run  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic white_char(input logic [15:0] c);
    white_char = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
                 c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
                 c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
                 c == 16'h3000;
  endfunction

  function automatic void escape_char(input logic [15:0] c, input logic sot);
    string       ent;
    int          n;
    int          pad;
    int          tab_mod;
    logic [15:0] run [htmlesc_pkg::MAX_RESULTS];
    html_beat_t  b;
    tab_mod = (htmlesc_pkg::TAB_STOP < 1) ? 1 : htmlesc_pkg::TAB_STOP;
    n = 0;
    ent = "";
    if (sot) begin
      col_mod = '0;
      prev_space = 1'b0;
    end
    if (c == htmlesc_pkg::CH_LF) begin
      ent = "<br>";
      col_mod = '0;
    end else if (c == htmlesc_pkg::CH_TAB) begin
      pad = (tab_mod - (int'(col_mod) % tab_mod)) % tab_mod;
      n = (1 + pad > htmlesc_pkg::MAX_RESULTS) ? htmlesc_pkg::MAX_RESULTS : 1 + pad;
      for (int i = 0; i < n; i++) run[i] = htmlesc_pkg::CH_NBSP;
      col_mod = '0;
    end else if (white_char(c)) begin
      run[0] = prev_space ? htmlesc_pkg::CH_NBSP : htmlesc_pkg::CH_SPACE;
      n = 1;
    end else if (c == htmlesc_pkg::CH_LT) begin
      ent = "&lt;";
    end else if (c == htmlesc_pkg::CH_GT) begin
      ent = "&gt;";
    end else if (c == htmlesc_pkg::CH_QUOT) begin
      ent = "&quot;";
    end else if (c == htmlesc_pkg::CH_APOS) begin
      ent = "&apos;";
    end else if (c == htmlesc_pkg::CH_AMP) begin
      ent = "&amp;";
    end else begin
      run[0] = c;
      n = 1;
    end
    if (ent.len() > 0) begin
      for (int i = 0; i < ent.len() && i < htmlesc_pkg::MAX_RESULTS; i++) begin
        run[i] = {8'h00, ent[i]};
      end
      n = (ent.len() > htmlesc_pkg::MAX_RESULTS) ? htmlesc_pkg::MAX_RESULTS : ent.len();
    end
    col_mod = htmlesc_pkg::COL_W'((int'(col_mod) % tab_mod + 1) % tab_mod);
    prev_space = (c == htmlesc_pkg::CH_SPACE);
    for (int i = 0; i < n; i++) begin
      b.ch = run[i];
      b.last = (i == n - 1);
      expected_beats.push_back(b);
    end
  endfunction

  function automatic logic [15:0] pick_white(input int idx);
    case (idx)
      0, 1, 2, 3, 4: pick_white = 16'h0009 + 16'(idx);
      5:             pick_white = 16'h0020;
      6:             pick_white = 16'h0085;
      7:             pick_white = 16'h00A0;
      8:             pick_white = 16'h1680;
      19:            pick_white = 16'h2028;
      20:            pick_white = 16'h2029;
      21:            pick_white = 16'h202F;
      22:            pick_white = 16'h205F;
      23:            pick_white = 16'h3000;
      default:       pick_white = 16'h2000 + 16'(idx - 9);
    endcase
  endfunction

  function automatic logic [15:0] random_char();
    int cls;
    cls = $urandom_range(0, 99);
    if (cls < 8)       random_char = htmlesc_pkg::CH_LF;
    else if (cls < 18) random_char = htmlesc_pkg::CH_TAB;
    else if (cls < 30) begin
      case ($urandom_range(0, 4))
        0:       random_char = htmlesc_pkg::CH_LT;
        1:       random_char = htmlesc_pkg::CH_GT;
        2:       random_char = htmlesc_pkg::CH_QUOT;
        3:       random_char = htmlesc_pkg::CH_APOS;
        default: random_char = htmlesc_pkg::CH_AMP;
      endcase
    end else if (cls < 45) random_char = htmlesc_pkg::CH_SPACE;
    else if (cls < 60) random_char = pick_white($urandom_range(0, 23));
    else if (cls < 80) random_char = 16'($urandom_range(16'h0021, 16'h007E));
    else               random_char = 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic add_char(input logic [15:0] c, input logic sot);
    text_item_t it;
    it.ch = c;
    it.sot = sot;
    char_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0 || in_valid || expected_beats.size() != 0)
      @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps, some of them empty.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        escape_char(character, start_of_text);
        items_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          next_item = char_queue.pop_front();
          in_valid <= 1'b1;
          character <= next_item.ch;
          start_of_text <= next_item.sot;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) :
                                                       $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each beat, stall on a shifting pattern with two long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat out_character=%h last_of_run=%b",
                   $time, out_character, last_of_run);
          errors++;
        end else begin
          got_exp = expected_beats.pop_front();
          if (got_exp.ch !== out_character || got_exp.last !== last_of_run) begin
            $display("%0t: expected out_character=%h last_of_run=%b, got %h %b",
                     $time, got_exp.ch, got_exp.last, out_character, last_of_run);
            errors++;
          end
        end
      end
      if (!hold1_done && beats_checked >= 120) begin
        hold1_done = 1;
        hold_left = 300;
      end else if (!hold2_done && beats_checked >= 500) begin
        hold2_done = 1;
        hold_left = 250;
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 9) < 6);
          default: stall_next = ~out_stall;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_to_html_escaper_core: mismatch");
      $finish;
    end
  end

  initial begin
    int rnd_count;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_char(16'h0000, 1'b1);
    add_char(16'hFFFF, 1'b0);
    add_char(htmlesc_pkg::CH_LF, 1'b0);
    add_char(htmlesc_pkg::CH_TAB, 1'b0);
    add_char(htmlesc_pkg::CH_TAB, 1'b1);
    add_char(16'h0041, 1'b0);
    add_char(htmlesc_pkg::CH_TAB, 1'b0);
    add_char(16'h0041, 1'b0);
    add_char(16'h0042, 1'b0);
    add_char(16'h0043, 1'b0);
    add_char(htmlesc_pkg::CH_TAB, 1'b0);
    add_char(htmlesc_pkg::CH_LT, 1'b0);
    add_char(htmlesc_pkg::CH_GT, 1'b0);
    add_char(htmlesc_pkg::CH_QUOT, 1'b0);
    add_char(htmlesc_pkg::CH_APOS, 1'b0);
    add_char(htmlesc_pkg::CH_AMP, 1'b0);
    add_char(htmlesc_pkg::CH_SPACE, 1'b0);
    add_char(16'h2000, 1'b0);
    add_char(16'h3000, 1'b0);
    add_char(htmlesc_pkg::CH_SPACE, 1'b0);
    add_char(16'h2028, 1'b1);
    add_char(16'h0008, 1'b0);
    add_char(16'h000E, 1'b0);
    add_char(16'h200B, 1'b0);
    add_char(16'h1FFF, 1'b0);
    wait_drained();

    rnd_count = 0;
    while (rnd_count < RANDOM_ITEMS) begin
      len = $urandom_range(1, 24);
      texts_made++;
      for (int i = 0; i < len; i++) begin
        add_char(random_char(), (i == 0) || ($urandom_range(0, 29) == 0));
        rnd_count++;
      end
      if (rnd_count >= RANDOM_ITEMS / 2 && rnd_count - len < RANDOM_ITEMS / 2) begin
        wait_drained();
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d characters in %0d random texts plus directed cases.",
             items_sent, texts_made);
    $display("Checked %0d output beats under bursty input and stalled output.", beats_checked);
    if (errors == 0) begin
      $display("text_to_html_escaper_core: match");
    end else begin
      $display("text_to_html_escaper_core: mismatch");
    end
    $finish;
  end

endmodule
